FILE: rtl/core/mlgr_pkg.sv
`timescale 1ns / 1ps

package mlgr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COLOR_BITS     = 8;
    localparam int DIV_STEPS      = 8;

    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_WALK
    } state_t;

    typedef enum logic [2:0] {
        SLOPE_VERT,
        SLOPE_STEEP_POS,
        SLOPE_SHALLOW_POS,
        SLOPE_SHALLOW_NEG,
        SLOPE_STEEP_NEG
    } slope_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_GE,
        COND_LT,
        COND_GT
    } cond_t;

    typedef struct packed {
        logic load_move;
        logic load_draw;
        logic setup;
        logic div_step;
        logic pix_step;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic div_last;
        logic pix_last;
    } status_t;

endpackage

FILE: rtl/core/mlgr_ctrl.sv
`timescale 1ns / 1ps

module mlgr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_opcode,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  mlgr_pkg::status_t status,
    output mlgr_pkg::cmd_t   cmd
);

    mlgr_pkg::state_t state_reg;
    mlgr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlgr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            mlgr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == mlgr_pkg::OP_DRAW) begin
                        cmd.load_draw = 1'b1;
                        state_next    = mlgr_pkg::ST_SETUP;
                    end else begin
                        cmd.load_move = 1'b1;
                    end
                end
            end
            mlgr_pkg::ST_SETUP: begin
                cmd.setup = 1'b1;
                // drop zero-length lines: no word goes out
                if (status.len_zero) begin
                    state_next = mlgr_pkg::ST_IDLE;
                end else begin
                    state_next = mlgr_pkg::ST_DIV;
                end
            end
            mlgr_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = mlgr_pkg::ST_WALK;
                end
            end
            mlgr_pkg::ST_WALK: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.pix_step = 1'b1;
                    if (status.pix_last) begin
                        state_next = mlgr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = mlgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/mlgr_datapath.sv
`timescale 1ns / 1ps

module mlgr_datapath #(
    parameter int COORD_BITS = mlgr_pkg::COORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mlgr_pkg::cmd_t                   cmd,
    output mlgr_pkg::status_t                status,
    input  logic [COORD_BITS-1:0]            s_point_x,
    input  logic [COORD_BITS-1:0]            s_point_y,
    output logic [COORD_BITS-1:0]            m_pixel_x,
    output logic [COORD_BITS-1:0]            m_pixel_y,
    output logic [mlgr_pkg::COLOR_BITS-1:0]  m_red,
    output logic [mlgr_pkg::COLOR_BITS-1:0]  m_green,
    output logic                             m_last
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam int QW = mlgr_pkg::COLOR_BITS;
    localparam int KW = $clog2(mlgr_pkg::DIV_STEPS);
    localparam logic [KW-1:0] DIV_LAST = KW'(mlgr_pkg::DIV_STEPS - 1);
    localparam logic [QW-1:0] COLOR_MAX = {QW{1'b1}};

    // stored start point and ordered endpoints
    logic [CW-1:0] start_x_reg, start_y_reg;
    logic [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;

    // walk state
    mlgr_pkg::slope_t slope_reg;
    mlgr_pkg::cond_t  cond_reg;
    logic                 rev_reg;
    logic [CW-1:0]        len_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        x_reg, y_reg;
    logic signed [DW-1:0] d_reg, inc_step_reg, inc_flat_reg;

    // gradient: red = q + r/len; step is qq + rq/len
    logic [QW-1:0]        q_reg, qq_reg;
    logic [CW-1:0]        r_reg, rq_reg;
    logic [KW-1:0]        div_cnt_reg;

    // ordering on draw
    logic          swap;
    logic [CW-1:0] p0_x, p0_y, p1_x, p1_y;

    always_comb begin
        swap = start_y_reg > s_point_y;
        p0_x = swap ? s_point_x : start_x_reg;
        p0_y = swap ? s_point_y : start_y_reg;
        p1_x = swap ? start_x_reg : s_point_x;
        p1_y = swap ? start_y_reg : s_point_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
        end else if (cmd.load_move) begin
            start_x_reg <= s_point_x;
            start_y_reg <= s_point_y;
        end else if (cmd.load_draw) begin
            start_x_reg <= p0_x;
            start_y_reg <= p0_y;
        end
    end

    // slope case decode
    logic signed [DW-1:0] dx_w, dy_w, two_dx, two_dy, ndx_w;
    logic [CW:0]          dx_s;
    logic [CW-1:0]        dy_u;
    mlgr_pkg::slope_t     slope_next;
    mlgr_pkg::cond_t      cond_next;
    logic                 rev_next;
    logic [CW-1:0]        len_next;
    logic signed [DW-1:0] d_next0, inc_step_next, inc_flat_next;

    always_comb begin
        dx_s   = {1'b0, x1_reg} - {1'b0, x0_reg};
        dy_u   = y1_reg - y0_reg;
        dx_w   = {{(DW-CW-1){dx_s[CW]}}, dx_s};
        dy_w   = {{(DW-CW){1'b0}}, dy_u};
        ndx_w  = -dx_w;
        two_dx = dx_w <<< 1;
        two_dy = dy_w <<< 1;
        slope_next    = mlgr_pkg::SLOPE_VERT;
        cond_next     = mlgr_pkg::COND_NEVER;
        rev_next      = 1'b0;
        len_next      = dy_u;
        d_next0       = '0;
        inc_step_next = '0;
        inc_flat_next = '0;
        if (dx_s == '0) begin
            slope_next = mlgr_pkg::SLOPE_VERT;
        end else if (!dx_s[CW]) begin
            if (dy_w > dx_w) begin
                slope_next    = mlgr_pkg::SLOPE_STEEP_POS;
                cond_next     = mlgr_pkg::COND_GE;
                d_next0       = two_dx - dy_w;
                inc_step_next = two_dx - two_dy;
                inc_flat_next = two_dx;
            end else begin
                slope_next    = mlgr_pkg::SLOPE_SHALLOW_POS;
                cond_next     = mlgr_pkg::COND_LT;
                len_next      = dx_w[CW-1:0];
                d_next0       = dx_w - two_dy;
                inc_step_next = two_dx - two_dy;
                inc_flat_next = -two_dy;
            end
        end else begin
            rev_next = 1'b1;
            if (dy_w <= ndx_w) begin
                slope_next    = mlgr_pkg::SLOPE_SHALLOW_NEG;
                cond_next     = mlgr_pkg::COND_GT;
                len_next      = ndx_w[CW-1:0];
                d_next0       = two_dy + dx_w;
                inc_step_next = two_dx + two_dy;
                inc_flat_next = two_dy;
            end else begin
                slope_next    = mlgr_pkg::SLOPE_STEEP_NEG;
                cond_next     = mlgr_pkg::COND_LT;
                d_next0       = dy_w + two_dx;
                inc_step_next = two_dx + two_dy;
                inc_flat_next = two_dx;
            end
        end
    end

    // restoring division of 255 by len, one quotient bit per cycle
    logic [CW:0]   div_trial;
    logic          div_ge;
    logic [CW-1:0] div_rem;

    always_comb begin
        div_trial = {r_reg, 1'b1};
        div_ge    = div_trial >= {1'b0, len_reg};
        div_rem   = div_ge ? CW'(div_trial - {1'b0, len_reg}) : div_trial[CW-1:0];
    end

    // one pixel step
    logic          take;
    logic [CW-1:0] take_w;
    logic [CW-1:0] x_next, y_next;
    logic [CW:0]   r_sum;
    logic          wrap, borrow;
    logic [CW-1:0] r_next;
    logic [QW-1:0] q_next;

    always_comb begin
        case (cond_reg)
            mlgr_pkg::COND_GE: take = !d_reg[DW-1];
            mlgr_pkg::COND_LT: take = d_reg[DW-1];
            mlgr_pkg::COND_GT: take = !d_reg[DW-1] && (d_reg != '0);
            default:           take = 1'b0;
        endcase
        take_w = {{(CW-1){1'b0}}, take};
        x_next = x_reg;
        y_next = y_reg;
        case (slope_reg)
            mlgr_pkg::SLOPE_VERT: begin
                y_next = y_reg + CW'(1);
            end
            mlgr_pkg::SLOPE_STEEP_POS: begin
                y_next = y_reg + CW'(1);
                x_next = x_reg + take_w;
            end
            mlgr_pkg::SLOPE_SHALLOW_POS: begin
                x_next = x_reg + CW'(1);
                y_next = y_reg + take_w;
            end
            mlgr_pkg::SLOPE_SHALLOW_NEG: begin
                x_next = x_reg + CW'(1);
                y_next = y_reg - take_w;
            end
            mlgr_pkg::SLOPE_STEEP_NEG: begin
                y_next = y_reg - CW'(1);
                x_next = x_reg + take_w;
            end
            default: begin
                x_next = x_reg;
                y_next = y_reg;
            end
        endcase

        r_sum  = {1'b0, r_reg} + {1'b0, rq_reg};
        wrap   = r_sum >= {1'b0, len_reg};
        borrow = r_reg < rq_reg;
        if (rev_reg) begin
            r_sum  = borrow ? ({1'b0, r_reg} + {1'b0, len_reg} - {1'b0, rq_reg})
                            : ({1'b0, r_reg} - {1'b0, rq_reg});
            r_next = r_sum[CW-1:0];
            q_next = q_reg - qq_reg - {{(QW-1){1'b0}}, borrow};
        end else begin
            r_next = wrap ? CW'(r_sum - {1'b0, len_reg}) : r_sum[CW-1:0];
            q_next = q_reg + qq_reg + {{(QW-1){1'b0}}, wrap};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_draw) begin
            x0_reg <= p0_x;
            y0_reg <= p0_y;
            x1_reg <= p1_x;
            y1_reg <= p1_y;
        end
        if (cmd.setup) begin
            slope_reg    <= slope_next;
            cond_reg     <= cond_next;
            rev_reg      <= rev_next;
            len_reg      <= len_next;
            cnt_reg      <= len_next;
            d_reg        <= d_next0;
            inc_step_reg <= inc_step_next;
            inc_flat_reg <= inc_flat_next;
            x_reg        <= rev_next ? x1_reg : x0_reg;
            y_reg        <= rev_next ? y1_reg : y0_reg;
            q_reg        <= rev_next ? COLOR_MAX : '0;
            r_reg        <= '0;
            qq_reg       <= '0;
            div_cnt_reg  <= '0;
        end
        if (cmd.div_step) begin
            qq_reg      <= {qq_reg[QW-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + KW'(1);
            // leave the pixel remainder cleared for the walk
            if (div_cnt_reg == DIV_LAST) begin
                rq_reg <= div_rem;
                r_reg  <= '0;
            end else begin
                r_reg  <= div_rem;
            end
        end
        if (cmd.pix_step) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            d_reg   <= d_reg + (take ? inc_step_reg : inc_flat_reg);
            q_reg   <= q_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_comb begin
        status.len_zero = len_next == '0;
        status.div_last = div_cnt_reg == DIV_LAST;
        status.pix_last = cnt_reg == CW'(1);
        m_pixel_x = x_reg;
        m_pixel_y = y_reg;
        m_red     = q_reg;
        m_green   = COLOR_MAX - q_reg - {{(QW-1){1'b0}}, r_reg != '0};
        m_last    = cnt_reg == CW'(1);
    end

endmodule

FILE: rtl/core/midpoint_line_gradient_raster_core.sv
`timescale 1ns / 1ps

// Line rasterizer with a red/green gradient along each line.
// Input channel (s_*): one word per command. opcode 0 moves the stored start
// point to (point_x, point_y); opcode 1 draws from the stored start point to
// (point_x, point_y). A move produces nothing.
// Output channel (m_*): one word per pixel, with red rising and green falling
// along the line; last marks the final pixel. The far endpoint is not plotted,
// so a zero-length draw produces no word.
// Sequence: a draw is taken, the slope case is set up in the next state, then a
// bit-per-cycle divider forms 255/len for the color steps, and then the pixel
// words leave at one per cycle while m_ready is high. A zero-length draw
// returns to idle after its setup state.
// One command is in flight at a time: s_ready is low from the draw until its
// last pixel is taken. A stalled receiver simply holds the current pixel word
// on the m_* ports; the walk advances only when m_ready is high.
// Reset clears the stored start point to (0, 0) and returns to idle.
module midpoint_line_gradient_raster_core #(
    parameter int COORD_BITS = mlgr_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [COORD_BITS-1:0]           s_point_x,
    input  logic [COORD_BITS-1:0]           s_point_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [COORD_BITS-1:0]           m_pixel_x,
    output logic [COORD_BITS-1:0]           m_pixel_y,
    output logic [mlgr_pkg::COLOR_BITS-1:0] m_red,
    output logic [mlgr_pkg::COLOR_BITS-1:0] m_green,
    output logic                            m_last
);

    mlgr_pkg::cmd_t    cmd;
    mlgr_pkg::status_t status;

    mlgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mlgr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .m_pixel_x (m_pixel_x),
        .m_pixel_y (m_pixel_y),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_last    (m_last)
    );

endmodule

FILE: test/mlgr_pixel_checker.sv
`timescale 1ns / 1ps

module mlgr_pixel_checker #(
    parameter int COORD_BITS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [COORD_BITS-1:0] s_point_x,
    input  logic [COORD_BITS-1:0] s_point_y,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [COORD_BITS-1:0] m_pixel_x,
    input  logic [COORD_BITS-1:0] m_pixel_y,
    input  logic [7:0]            m_red,
    input  logic [7:0]            m_green,
    input  logic                  m_last,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [7:0]            red;
        logic [7:0]            green;
        logic                  last;
    } pixel_t;

    pixel_t                pixel_q[$];
    pixel_t                want;
    logic [COORD_BITS-1:0] anchor_x = '0;
    logic [COORD_BITS-1:0] anchor_y = '0;
    int                    errors   = 0;

    function automatic void push_pixel(int x, int y, int pos, int span);
        pixel_t p;
        p.x     = COORD_BITS'(x);
        p.y     = COORD_BITS'(y);
        p.red   = 8'((255 * pos) / span);
        p.green = 8'((255 * (span - pos)) / span);
        p.last  = 1'b0;
        pixel_q.push_back(p);
    endfunction

    // Walk one line from the stored start point to (px, py).
    function automatic void trace_line(int px, int py);
        int x0, y0, x1, y1, dx, dy, d, a, x, y, t, first;
        first = pixel_q.size();
        x0 = anchor_x;
        y0 = anchor_y;
        x1 = px;
        y1 = py;
        if (y0 > y1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx == 0) begin
            for (y = y0; y < y1; y++)
                push_pixel(x0, y, y - y0, dy);
        end else if (dx > 0 && dy > dx) begin
            d = 2 * dx - dy;
            x = x0;
            for (y = y0; y < y1; y++) begin
                push_pixel(x, y, y - y0, dy);
                if (d >= 0) begin
                    x++;
                    d += 2 * dx - 2 * dy;
                end else begin
                    d += 2 * dx;
                end
            end
        end else if (dx > 0) begin
            d = dx - 2 * dy;
            y = y0;
            for (x = x0; x < x1; x++) begin
                push_pixel(x, y, x - x0, dx);
                if (d < 0) begin
                    y++;
                    d += 2 * dx - 2 * dy;
                end else begin
                    d -= 2 * dy;
                end
            end
        end else begin
            a = -dx;
            if (dy <= a) begin
                // start at the far end, red at full
                d = 2 * dy - a;
                y = y1;
                for (x = x1; x < x0; x++) begin
                    push_pixel(x, y, x0 - x, a);
                    if (d <= 0) begin
                        d += 2 * dy;
                    end else begin
                        y--;
                        d -= 2 * a - 2 * dy;
                    end
                end
            end else begin
                d = dy - 2 * a;
                x = x1;
                for (y = y1; y > y0; y--) begin
                    push_pixel(x, y, y - y0, dy);
                    if (d >= 0) begin
                        d -= 2 * a;
                    end else begin
                        x++;
                        d -= 2 * a - 2 * dy;
                    end
                end
            end
        end
        if (pixel_q.size() > first)
            pixel_q[pixel_q.size() - 1].last = 1'b1;
        anchor_x = COORD_BITS'(x0);
        anchor_y = COORD_BITS'(y0);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            anchor_x = '0;
            anchor_y = '0;
            pixel_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_opcode == mlgr_pkg::OP_MOVE) begin
                    anchor_x = s_point_x;
                    anchor_y = s_point_y;
                end else begin
                    trace_line(s_point_x, s_point_y);
                end
            end
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected word x=%0d y=%0d r=%0d g=%0d last=%0b",
                                 $realtime, m_pixel_x, m_pixel_y, m_red, m_green, m_last);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_pixel_x !== want.x || m_pixel_y !== want.y || m_red !== want.red ||
                        m_green !== want.green || m_last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: expected x=%0d y=%0d r=%0d g=%0d last=%0b",
                                     $realtime, want.x, want.y, want.red, want.green,
                                     want.last);
                            $display("%0t:      got x=%0d y=%0d r=%0d g=%0d last=%0b",
                                     $realtime, m_pixel_x, m_pixel_y, m_red, m_green,
                                     m_last);
                        end
                    end
                end
            end
        end
        fail_count    <= errors;
        pending_count <= pixel_q.size();
    end

endmodule

FILE: test/tb_midpoint_line_gradient_raster_core.sv
`timescale 1ns / 1ps

module tb_midpoint_line_gradient_raster_core;

    localparam int CB          = 6;
    localparam int CMAX        = (1 << CB) - 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 44;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    logic          s_opcode  = mlgr_pkg::OP_MOVE;
    logic [CB-1:0] s_point_x = '0;
    logic [CB-1:0] s_point_y = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    logic [CB-1:0] m_pixel_x;
    logic [CB-1:0] m_pixel_y;
    logic [7:0]    m_red;
    logic [7:0]    m_green;
    logic          m_last;

    int   fail_count;
    int   pending_count;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off_req   = 1'b0;
    int   sent_items;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    midpoint_line_gradient_raster_core #(
        .COORD_BITS(CB)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_point_x(s_point_x),
        .s_point_y(s_point_y),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_red    (m_red),
        .m_green  (m_green),
        .m_last   (m_last)
    );

    mlgr_pixel_checker #(
        .COORD_BITS(CB)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_last       (m_last),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_word(input logic op, input logic [CB-1:0] x, input logic [CB-1:0] y);
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_point_x <= x;
        s_point_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
        // idle before the next word, if the dice say so
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    task automatic draw_from(input int ax, input int ay, input int bx, input int by);
        send_word(mlgr_pkg::OP_MOVE, CB'(ax), CB'(ay));
        send_word(mlgr_pkg::OP_DRAW, CB'(bx), CB'(by));
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > CMAX)
            return CMAX;
        return v;
    endfunction

    task automatic send_random;
        int kind, ax, ay, bx, by, sx, sy, kmax;
        kind = $urandom_range(9);
        ax   = $urandom_range(CMAX);
        ay   = $urandom_range(CMAX);
        bx   = $urandom_range(CMAX);
        by   = $urandom_range(CMAX);
        case (kind)
            0: begin
                send_word(mlgr_pkg::OP_MOVE, CB'(ax), CB'(ay));
            end
            1, 2: begin
                // chain off whatever start point the last command left
                send_word(mlgr_pkg::OP_DRAW, CB'(bx), CB'(by));
            end
            3: begin
                draw_from(ax, ay, ax, by);
            end
            4: begin
                draw_from(ax, ay, bx, ay);
            end
            5: begin
                sx   = $urandom_range(1) ? 1 : -1;
                sy   = $urandom_range(1) ? 1 : -1;
                kmax = (sx > 0) ? CMAX - ax : ax;
                if (((sy > 0) ? CMAX - ay : ay) < kmax)
                    kmax = (sy > 0) ? CMAX - ay : ay;
                kmax = $urandom_range(kmax);
                draw_from(ax, ay, ax + sx * kmax, ay + sy * kmax);
            end
            6, 7: begin
                draw_from(ax, ay, clamp_coord(ax + int'($urandom_range(16)) - 8),
                          clamp_coord(ay + int'($urandom_range(16)) - 8));
            end
            default: begin
                draw_from(ax, ay, bx, by);
            end
        endcase
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = sent_items + PHASE_ITEMS;
        while (sent_items < stop_at)
            send_random();
    endtask

    initial begin
        sent_items = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every slope case, zero length, extremes, equal y
        send_word(mlgr_pkg::OP_DRAW, CB'(0), CB'(0));
        send_word(mlgr_pkg::OP_DRAW, CB'(CMAX), CB'(CMAX));
        send_word(mlgr_pkg::OP_DRAW, CB'(CMAX), CB'(0));
        draw_from(CMAX, 0, 0, 0);
        draw_from(10, 0, 10, CMAX);
        draw_from(5, CMAX, 5, 0);
        draw_from(0, 0, 20, CMAX);
        draw_from(0, 10, CMAX, 20);
        draw_from(CMAX, 0, 0, 30);
        draw_from(40, 0, 0, CMAX);
        draw_from(CMAX, 0, 0, CMAX);
        draw_from(30, 30, 10, 30);
        draw_from(0, 0, 1, 0);
        send_word(mlgr_pkg::OP_DRAW, CB'(0), CB'(1));
        send_word(mlgr_pkg::OP_DRAW, CB'(CMAX), CB'(CMAX));

        hold_off_req <= 1'b1;
        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(21, 21);
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending_count != 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
